[design/shuffled_lehmer_random_generator_core_macros.svh]
// assertion macros shared by the generator modules
`ifndef SHUFFLED_LEHMER_RANDOM_GENERATOR_CORE_MACROS_SVH
`define SHUFFLED_LEHMER_RANDOM_GENERATOR_CORE_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SLRG_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slrg assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define SLRG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slrg assertion failed");

`endif

[design/slrg_pkg.sv]
// shared constants and controller/datapath interface types for the generator
package slrg_pkg;

    // generator value and table geometry
    localparam int VAL_W       = 31;
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int WARM_STEPS  = TABLE_DEPTH + 8;
    localparam int CNT_W       = $clog2(WARM_STEPS);

    // multiplier and modulus
    localparam int MULT_W = 15;
    localparam int PROD_W = VAL_W + MULT_W;
    localparam logic [MULT_W-1:0] LEHMER_MULT = 15'd16807;
    localparam logic [VAL_W-1:0]  LEHMER_MOD  = 31'h7FFF_FFFF;

    // input word command codes
    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic             load_seed;
        logic             force_one;
        logic             mul;
        logic             warm_step;
        logic             warm_wr;
        logic             warm_last;
        logic [IDX_W-1:0] wr_idx;
        logic             draw_finish;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic need_warm;
        logic out_free;
    } t_dp_status;

endpackage

[design/shuffled_lehmer_random_generator_core.sv]
// top level of the shuffled lehmer generator: controller plus datapath
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------
//  in      | input     | i_in_valid / o_in_ready    | i_cmd, i_seed
//  out     | output    | o_out_valid / i_out_ready  | o_sample
//
// a reseed word is taken in the idle state; a draw steps through accept, multiply, fold/write
// a draw that needs warm-up first runs 40 steps, each through the one 31x15 multiplier
// and the modulus fold
// the shuffle table is a 32-entry memory, one write and one registered read a cycle
// synchronous active-low reset; the table itself is not cleared
// a full output register holds a draw in its fold/write state; no reseed is taken meanwhile
module shuffled_lehmer_random_generator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_cmd,
    input  logic [slrg_pkg::VAL_W-1:0]  i_seed,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [slrg_pkg::VAL_W-1:0]  o_sample
);
    import slrg_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencer
    slrg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // arithmetic and storage
    slrg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seed      (i_seed),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_sample    (o_sample)
    );

endmodule

[design/slrg_ctrl.sv]
// controller state machine: sequences warm-up steps and draws
`include "shuffled_lehmer_random_generator_core_macros.svh"

module slrg_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_cmd,
    input  slrg_pkg::t_dp_status  i_status,
    output logic                  o_in_ready,
    output slrg_pkg::t_dp_cmd     o_cmd
);
    import slrg_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_W_MUL = 3'd1;
    localparam logic [2:0] S_W_RED = 3'd2;
    localparam logic [2:0] S_D_MUL = 3'd3;
    localparam logic [2:0] S_D_RED = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_accept;

    // words are taken only between operations
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // next state and command decode
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == CMD_RESEED) begin
                        o_cmd.load_seed = 1'b1;
                    end else if (i_status.need_warm) begin
                        o_cmd.force_one = 1'b1;
                        n_cnt           = CNT_W'(WARM_STEPS - 1);
                        n_state         = S_W_MUL;
                    end else begin
                        n_state = S_D_MUL;
                    end
                end
            end
            S_W_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_W_RED;
            end
            S_W_RED: begin
                o_cmd.warm_step = 1'b1;
                o_cmd.warm_wr   = (r_cnt < CNT_W'(TABLE_DEPTH));
                o_cmd.wr_idx    = r_cnt[IDX_W-1:0];
                if (r_cnt == '0) begin
                    o_cmd.warm_last = 1'b1;
                    n_state         = S_D_MUL;
                end else begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_W_MUL;
                end
            end
            S_D_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_D_RED;
            end
            S_D_RED: begin
                // hold here while the output register is still occupied
                if (i_status.out_free) begin
                    o_cmd.draw_finish = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // checks
    `SLRG_ASSERT_NEXT(a_warm_last_to_draw, o_cmd.warm_last, r_state == S_D_MUL)
    `SLRG_ASSERT_IMPL(a_cnt_in_range, 1'b1, r_cnt < CNT_W'(WARM_STEPS))
    `SLRG_ASSERT_NEXT(a_warm_start, w_accept && i_cmd == CMD_DRAW && i_status.need_warm, r_state == S_W_MUL)

endmodule

[design/slrg_dp.sv]
// datapath: generator step, shuffle table memory, held value and output register
`include "shuffled_lehmer_random_generator_core_macros.svh"

module slrg_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [slrg_pkg::VAL_W-1:0]    i_seed,
    input  slrg_pkg::t_dp_cmd             i_cmd,
    output slrg_pkg::t_dp_status          o_status,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [slrg_pkg::VAL_W-1:0]    o_sample
);
    import slrg_pkg::*;

    logic [VAL_W-1:0]  r_gen;
    logic [VAL_W-1:0]  r_held;
    logic              r_needs_init;
    logic [PROD_W-1:0] r_prod;
    logic [VAL_W-1:0]  r_rdata;
    logic [VAL_W-1:0]  r_table [TABLE_DEPTH];
    logic [VAL_W:0]    w_sum;
    logic [VAL_W-1:0]  w_next;
    logic [IDX_W-1:0]  w_j;
    logic [IDX_W-1:0]  w_k;
    logic [VAL_W-1:0]  w_lhs;
    logic [VAL_W-1:0]  w_rhs;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;

    // fold the product: 2^31 == 1 modulo 2^31-1, then one conditional subtract
    assign w_sum  = {1'b0, r_prod[VAL_W-1:0]} + (VAL_W+1)'(r_prod[PROD_W-1:VAL_W]);
    assign w_next = (w_sum >= {1'b0, LEHMER_MOD}) ? VAL_W'(w_sum - {1'b0, LEHMER_MOD})
                                                  : w_sum[VAL_W-1:0];

    // table index floor(D*held/(2^31-2+D)): top bits, minus one when the
    // low part falls short of the k*(D-2) correction
    assign w_k   = r_held[VAL_W-1 -: IDX_W];
    assign w_lhs = {r_held[VAL_W-IDX_W-1:0], {IDX_W{1'b0}}};
    assign w_rhs = VAL_W'(w_k) * VAL_W'(TABLE_DEPTH - 2);
    assign w_j   = (w_lhs >= w_rhs) ? w_k : w_k - 1'b1;

    // status to the controller
    assign o_status.need_warm = r_needs_init || (r_held == '0) || (r_gen == '0);
    assign o_status.out_free  = !o_out_valid || i_out_ready;

    // multiplier stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_gen) * PROD_W'(LEHMER_MULT);
        end
    end

    // generator state, held value and init flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen        <= '0;
            r_held       <= '0;
            r_needs_init <= 1'b1;
        end else begin
            if (i_cmd.load_seed) begin
                r_gen        <= i_seed;
                r_needs_init <= 1'b1;
            end
            if (i_cmd.force_one && r_gen == '0) begin
                r_gen <= VAL_W'(1);
            end
            if (i_cmd.warm_step || i_cmd.draw_finish) begin
                r_gen <= w_next;
            end
            if (i_cmd.warm_last) begin
                r_held       <= w_next;
                r_needs_init <= 1'b0;
            end
            if (i_cmd.draw_finish) begin
                r_held <= r_rdata;
            end
        end
    end

    // shuffle table: one write port, one registered read port at the index
    assign w_we    = i_cmd.warm_wr || i_cmd.draw_finish;
    assign w_waddr = i_cmd.draw_finish ? w_j : i_cmd.wr_idx;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_table[w_waddr] <= w_next;
        end
        r_rdata <= r_table[w_j];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.draw_finish) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.draw_finish) begin
            o_sample <= r_rdata;
        end
    end

    // checks
    `SLRG_ASSERT_IMPL(a_sample_below_mod, o_out_valid, o_sample != LEHMER_MOD)
    `SLRG_ASSERT_IMPL(a_finish_when_free, i_cmd.draw_finish, o_status.out_free)

endmodule
